// ===== rtl/pded_pkg.sv =====
package pded_pkg;

   typedef logic [2:0] func_type;

   localparam func_type FUNC_TICK  = 3'd0;
   localparam func_type FUNC_LEVEL = 3'd1;
   localparam func_type FUNC_RISE  = 3'd2;
   localparam func_type FUNC_FALL  = 3'd3;
   localparam func_type FUNC_CLEAR = 3'd4;

   localparam int unsigned HIST_W = 16;
   localparam logic [HIST_W-1:0] PAT_RISE = 16'h00FF;
   localparam logic [HIST_W-1:0] PAT_FALL = 16'hFF00;

   // Per-lane commands issued by the decoder for one accepted transaction.
   typedef struct packed {
      logic tick;
      logic pin;
      logic clr_rise;
      logic clr_fall;
   } lane_ctrl_type;

   // What one lane reports back to the merge stage.
   typedef struct packed {
      logic level;
      logic rise;
      logic fall;
   } lane_status_type;

endpackage

// ===== rtl/pded_lane.sv =====
module pded_lane (
   input  logic                     clock,
   input  logic                     reset,
   input  pded_pkg::lane_ctrl_type  ctrl,
   output pded_pkg::lane_status_type status
);
   import pded_pkg::*;

   logic [HIST_W-1:0] history_ff, history_in;
   logic              level_ff, level_in;
   logic              rise_ff, rise_in;
   logic              fall_ff, fall_in;
   logic [HIST_W-1:0] shifted;

   assign shifted = {history_ff[HIST_W-2:0], ctrl.pin};

   always_comb begin
      history_in = history_ff;
      level_in   = level_ff;
      rise_in    = rise_ff;
      fall_in    = fall_ff;
      if (ctrl.tick) begin
         history_in = shifted;
         if (shifted == PAT_FALL) begin
            level_in = 1'b0;
            fall_in  = 1'b1;
         end else if (shifted == PAT_RISE) begin
            level_in = 1'b1;
            rise_in  = 1'b1;
         end
      end else begin
         if (ctrl.clr_rise) begin
            rise_in = 1'b0;
         end
         if (ctrl.clr_fall) begin
            fall_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
         level_ff   <= 1'b0;
         rise_ff    <= 1'b0;
         fall_ff    <= 1'b0;
      end else begin
         history_ff <= history_in;
         level_ff   <= level_in;
         rise_ff    <= rise_in;
         fall_ff    <= fall_in;
      end
   end

   assign status.level = level_ff;
   assign status.rise  = rise_ff;
   assign status.fall  = fall_ff;

   // The level always agrees with a matching pattern still held in the history.
   assert property (@(posedge clock) disable iff (reset)
      (history_ff == PAT_RISE) |-> level_ff)
      else $error("level low while history holds the rising pattern");

   assert property (@(posedge clock) disable iff (reset)
      (history_ff == PAT_FALL) |-> !level_ff)
      else $error("level high while history holds the falling pattern");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rise_ff) |-> (history_ff == PAT_RISE))
      else $error("rising flag set without the rising pattern");

   assert property (@(posedge clock) disable iff (reset)
      $rose(fall_ff) |-> (history_ff == PAT_FALL))
      else $error("falling flag set without the falling pattern");

endmodule

// ===== rtl/pded_merge.sv =====
module pded_merge #(
   parameter int NUM_INPUTS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  pded_pkg::func_type        func,
   input  logic [7:0]                channel,
   input  logic                      in_range,
   input  pded_pkg::lane_status_type status [NUM_INPUTS],
   output logic                      out_free,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_value
);
   import pded_pkg::*;

   localparam int IDX_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;

   logic            valid_ff, valid_in;
   logic            value_ff, value_in;
   lane_status_type picked;
   logic            read_bit;

   assign picked = in_range ? status[channel[IDX_W-1:0]] : '0;

   always_comb begin
      case (func)
         FUNC_LEVEL: read_bit = picked.level;
         FUNC_RISE:  read_bit = picked.rise;
         FUNC_FALL:  read_bit = picked.fall;
         default:    read_bit = 1'b0;
      endcase
   end

   // The output register can take a new transaction when empty or draining.
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (accept) begin
         valid_in = 1'b1;
         value_in = read_bit & in_range;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_value = value_ff;

   assert property (@(posedge clock) disable iff (reset)
      (accept && !in_range) |=> !value_ff)
      else $error("out-of-range query returned a nonzero value");

   assert property (@(posedge clock) disable iff (reset)
      (accept && func == FUNC_TICK) |=> !value_ff)
      else $error("tick returned a nonzero value");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> valid_ff)
      else $error("accepted transaction produced no result");

endmodule

// ===== rtl/pattern_debounce_edge_detector.sv =====
// Pattern debouncer with sticky edge flags for NUM_INPUTS pin channels.
// Request channel (req_valid/req_ready) carries one transaction: req_func
// selects a tick, which shifts every channel's req_pins bit into its 16-bit
// history, or a query on req_channel (read level, read and clear the rising
// or falling flag, clear both flags). Every request yields exactly one
// response on rsp_valid/rsp_ready with a single bit rsp_value; ticks,
// clears and queries on channels at or above NUM_INPUTS return 0.
// All channels are separate lanes that update in the cycle a request is
// accepted; a merge stage selects the queried lane into the output register.
// rsp_valid rises in the cycle after acceptance, and one request is
// taken every cycle as long as the response side keeps up. When the receiver
// stalls, the response is held and req_ready drops until it is taken, so
// nothing is lost. Reset clears all histories, levels, flags and the
// output valid flag, and req_ready stays low while reset is held.
module pattern_debounce_edge_detector #(
   parameter int NUM_INPUTS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pded_pkg::func_type  req_func,
   input  logic [31:0]         req_pins,
   input  logic [7:0]          req_channel,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_value
);
   import pded_pkg::*;

   logic            accept;
   logic            out_free;
   logic            in_range;
   logic            is_tick;
   logic            clr_rise_op;
   logic            clr_fall_op;
   lane_ctrl_type   ctrl   [NUM_INPUTS];
   lane_status_type status [NUM_INPUTS];

   assign req_ready   = out_free && !reset;
   assign accept      = req_valid && req_ready;
   assign in_range    = ({24'd0, req_channel} < 32'(NUM_INPUTS));
   assign is_tick     = (req_func == FUNC_TICK);
   assign clr_rise_op = (req_func == FUNC_RISE) || (req_func == FUNC_CLEAR);
   assign clr_fall_op = (req_func == FUNC_FALL) || (req_func == FUNC_CLEAR);

   for (genvar i = 0; i < NUM_INPUTS; i++) begin : g_lane
      logic hit;
      assign hit = accept && in_range && (req_channel == 8'(i));
      assign ctrl[i].tick     = accept && is_tick;
      assign ctrl[i].pin      = req_pins[i];
      assign ctrl[i].clr_rise = hit && clr_rise_op;
      assign ctrl[i].clr_fall = hit && clr_fall_op;

      pded_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl[i]),
         .status (status[i])
      );
   end

   pded_merge #(
      .NUM_INPUTS (NUM_INPUTS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .func      (req_func),
      .channel   (req_channel),
      .in_range  (in_range),
      .status    (status),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_value (rsp_value)
   );

endmodule

// ===== tb/pattern_debounce_edge_detector_test.sv =====
`timescale 1ns / 1ps

module pattern_debounce_edge_detector_test;
   import pded_pkg::*;

   localparam int NUM_CH = 32;
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_ITEMS = 1320;

   localparam func_type FUNC_RSVD5 = 3'd5;
   localparam func_type FUNC_RSVD6 = 3'd6;
   localparam func_type FUNC_RSVD7 = 3'd7;

   typedef struct {
      func_type    func;
      logic [31:0] pins;
      logic [7:0]  chan;
      int unsigned reps;
      bit          typed;
      bit          value;
   } stim_row_type;

   typedef struct {
      func_type   func;
      logic [7:0] chan;
      bit         value;
   } expected_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   func_type    req_func = FUNC_TICK;
   logic [31:0] req_pins = '0;
   logic [7:0]  req_channel = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_value;

   // Predicted debouncer state.
   logic [15:0] hist_shadow [NUM_CH];
   bit          level_shadow [NUM_CH];
   bit          rise_shadow [NUM_CH];
   bit          fall_shadow [NUM_CH];

   // Slowly changing pin levels with occasional bounce noise for the random part.
   bit          pin_target [NUM_CH];
   int unsigned pin_dwell [NUM_CH];

   expected_rsp_type expected_values [$];
   expected_rsp_type head;
   int unsigned   mismatch_count = 0;
   int unsigned   cycle_count = 0;
   int unsigned   rsp_hold = 0;
   bit            quiet_phase = 1'b0;

   stim_row_type directed_rows [0:17] = '{
      '{FUNC_LEVEL, 32'h0000_0000, 8'd0,   1, 1'b1, 1'b0},
      '{FUNC_RISE,  32'hFFFF_FFFF, 8'd31,  1, 1'b1, 1'b0},
      '{FUNC_FALL,  32'h0000_0000, 8'd17,  1, 1'b1, 1'b0},
      '{FUNC_CLEAR, 32'hFFFF_FFFF, 8'd3,   1, 1'b1, 1'b0},
      '{FUNC_LEVEL, 32'h0000_0000, 8'd32,  1, 1'b1, 1'b0},
      '{FUNC_RISE,  32'hFFFF_FFFF, 8'd255, 1, 1'b1, 1'b0},
      '{FUNC_RSVD5, 32'h0000_0000, 8'd0,   1, 1'b1, 1'b0},
      '{FUNC_RSVD6, 32'hFFFF_FFFF, 8'd40,  1, 1'b1, 1'b0},
      '{FUNC_RSVD7, 32'hFFFF_FFFF, 8'd255, 1, 1'b1, 1'b0},
      '{FUNC_TICK,  32'h0000_0000, 8'd0,   1, 1'b1, 1'b0},
      '{FUNC_TICK,  32'hAAAA_5555, 8'd0,   8, 1'b1, 1'b0},
      '{FUNC_LEVEL, 32'h0000_0000, 8'd0,   1, 1'b0, 1'b0},
      '{FUNC_LEVEL, 32'h0000_0000, 8'd1,   1, 1'b0, 1'b0},
      '{FUNC_RISE,  32'h0000_0000, 8'd0,   2, 1'b0, 1'b0},
      '{FUNC_FALL,  32'h0000_0000, 8'd0,   1, 1'b0, 1'b0},
      '{FUNC_CLEAR, 32'h0000_0000, 8'd2,   1, 1'b1, 1'b0},
      '{FUNC_RISE,  32'h0000_0000, 8'd2,   1, 1'b0, 1'b0},
      '{FUNC_FALL,  32'h0000_0000, 8'd128, 1, 1'b1, 1'b0}
   };

   pattern_debounce_edge_detector #(
      .NUM_INPUTS(NUM_CH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_func    (req_func),
      .req_pins    (req_pins),
      .req_channel (req_channel),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_value   (rsp_value)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Applies one transaction to the predicted state and returns the bit read.
   function automatic bit debounce_step(func_type f, logic [31:0] pins, logic [7:0] ch);
      logic [15:0] h;
      bit          v;
      v = 1'b0;
      if (f == FUNC_TICK) begin
         for (int i = 0; i < NUM_CH; i++) begin
            h = {hist_shadow[i][14:0], pins[i]};
            hist_shadow[i] = h;
            if (h == PAT_FALL) begin
               level_shadow[i] = 1'b0;
               fall_shadow[i] = 1'b1;
            end else if (h == PAT_RISE) begin
               level_shadow[i] = 1'b1;
               rise_shadow[i] = 1'b1;
            end
         end
      end else if (ch < NUM_CH) begin
         case (f)
            FUNC_LEVEL: begin
               v = level_shadow[ch];
            end
            FUNC_RISE: begin
               v = rise_shadow[ch];
               rise_shadow[ch] = 1'b0;
            end
            FUNC_FALL: begin
               v = fall_shadow[ch];
               fall_shadow[ch] = 1'b0;
            end
            FUNC_CLEAR: begin
               rise_shadow[ch] = 1'b0;
               fall_shadow[ch] = 1'b0;
            end
            default: ;
         endcase
      end
      return v;
   endfunction

   // A pin holds its level for at least ten ticks before it may switch, so
   // most switches leave a clean eight-and-eight pattern in the history.
   function automatic logic [31:0] settled_pins();
      logic [31:0] p;
      for (int i = 0; i < NUM_CH; i++) begin
         pin_dwell[i]++;
         if (pin_dwell[i] > 9 && $urandom_range(0, 7) == 0) begin
            pin_target[i] = ~pin_target[i];
            pin_dwell[i] = 0;
         end
         p[i] = pin_target[i] ^ ($urandom_range(0, 39) == 0);
      end
      return p;
   endfunction

   function automatic int unsigned idle_cycles();
      int unsigned r;
      if (quiet_phase) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   task automatic note_mismatch(string what, bit exp_v);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s: expected %0d, got %0d", $realtime, what, exp_v, rsp_value);
      end
   endtask

   task automatic send_item(func_type f, logic [31:0] p, logic [7:0] c, bit typed,
                            bit typed_v);
      expected_rsp_type e;
      bit            v;
      req_valid <= 1'b1;
      req_func <= f;
      req_pins <= p;
      req_channel <= c;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      v = debounce_step(f, p, c);
      e.func = f;
      e.chan = c;
      e.value = typed ? typed_v : v;
      expected_values.push_back(e);
   endtask

   task automatic sender_gap();
      int unsigned g;
      g = idle_cycles();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // The valid line is only dropped here when something is still pending, so
   // a following send never drives it a second time in the same step.
   task automatic wait_drained();
      if (expected_values.size() != 0) begin
         req_valid <= 1'b0;
         while (expected_values.size() != 0) begin
            @(posedge clock);
         end
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         automatic int unsigned g = idle_cycles();
         rsp_ready <= (g == 0);
         if (g > 0) begin
            rsp_hold <= g - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_values.size() == 0) begin
            note_mismatch("response with no transaction pending", 1'b0);
         end else begin
            head = expected_values.pop_front();
            if (rsp_value !== head.value) begin
               note_mismatch($sformatf("func %0d channel %0d", head.func, head.chan),
                             head.value);
            end
         end
      end
   end

   initial begin
      int unsigned r;
      func_type    f;
      logic [31:0] p;
      logic [7:0]  c;
      for (int i = 0; i < NUM_CH; i++) begin
         hist_shadow[i] = '0;
         level_shadow[i] = 1'b0;
         rise_shadow[i] = 1'b0;
         fall_shadow[i] = 1'b0;
         pin_target[i] = 1'b0;
         pin_dwell[i] = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k]) begin
         repeat (directed_rows[k].reps) begin
            send_item(directed_rows[k].func, directed_rows[k].pins, directed_rows[k].chan,
                      directed_rows[k].typed, directed_rows[k].value);
            sender_gap();
         end
      end
      wait_drained();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) begin
            quiet_phase = ($urandom_range(0, 3) == 0);
         end
         if (n == RANDOM_ITEMS / 2) begin
            wait_drained();
         end
         p = $urandom();
         c = $urandom_range(0, NUM_CH - 1);
         r = $urandom_range(0, 99);
         if (r < 50) begin
            f = FUNC_TICK;
            p = settled_pins();
         end else if (r < 55) begin
            f = FUNC_TICK;
         end else if (r < 90) begin
            f = func_type'($urandom_range(FUNC_LEVEL, FUNC_CLEAR));
         end else if (r < 96) begin
            f = func_type'($urandom_range(FUNC_LEVEL, FUNC_CLEAR));
            c = $urandom_range(NUM_CH, 255);
         end else begin
            f = func_type'($urandom_range(FUNC_RSVD5, FUNC_RSVD7));
            c = $urandom_range(0, 255);
         end
         send_item(f, p, c, 1'b0, 1'b0);
         sender_gap();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/pded_pkg.sv
rtl/pded_lane.sv
rtl/pded_merge.sv
rtl/pattern_debounce_edge_detector.sv
tb/pattern_debounce_edge_detector_test.sv
